### rtl/srec_record_encoder_core_macros.svh
// Assertion macros for the S-record encoder.
// Used by srec_record_encoder_core; expects clk and rst in scope.
`ifndef SREC_RECORD_ENCODER_CORE_MACROS_SVH
`define SREC_RECORD_ENCODER_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define SREC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define SREC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) ante |=> cons) else $error(msg);
`else
`define SREC_ASSERT(label, prop, msg)
`define SREC_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

### rtl/srec_pkg.sv
// Shared types, constants and the hex digit function of the S-record encoder.
// No dependencies.
`default_nettype none
package srec_pkg;

  localparam int unsigned BPL_DEFAULT = 16;
  localparam int unsigned LINE_CAP    = 16;
  localparam int unsigned LINE_AW     = 4;
  localparam int unsigned IDX_W       = 5;
  localparam int unsigned FIFO_DEPTH  = 2;

  localparam logic [6:0] CHAR_S  = 7'h53;
  localparam logic [6:0] CHAR_NL = 7'h0A;

  localparam logic [3:0] REC_S0 = 4'd0;
  localparam logic [3:0] REC_S1 = 4'd1;
  localparam logic [3:0] REC_S5 = 4'd5;
  localparam logic [3:0] REC_S9 = 4'd9;

  localparam logic [7:0] COUNT_BASE = 8'd3;
  localparam logic [7:0] COUNT_HDR  = 8'd7;

  typedef struct packed {
    logic [3:0]                rtype;
    logic [7:0]                count;
    logic [15:0]               addr;
    logic [LINE_CAP-1:0][7:0]  data;
    logic [7:0]                cksum;
    logic                      last;
  } record_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_status_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_HDR,
    F_LINE,
    F_S5,
    F_S9
  } front_state_t;

  typedef enum logic [2:0] {
    B_IDLE,
    B_S,
    B_TYPE,
    B_HEX,
    B_NL
  } back_state_t;

  function automatic logic [6:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) begin
      return 7'(7'h30 + 7'(v));
    end else begin
      return 7'(7'h37 + 7'(v));
    end
  endfunction

endpackage
`default_nettype wire

### rtl/srec_front.sv
// Front end: accepts bytes, buffers a line, builds record descriptors.
// Depends on srec_pkg.
`default_nettype none
module srec_front #(
  parameter int unsigned BYTES_PER_LINE = srec_pkg::BPL_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [31:0]           cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,
  input  logic                  s_tuser,
  output logic                  push,
  output srec_pkg::record_t     push_rec,
  input  srec_pkg::fifo_status_t fifo_st
);
  import srec_pkg::*;

  localparam int unsigned FILL_W = $clog2(BYTES_PER_LINE + 1);

  front_state_t             fstate, fstate_next;
  logic [31:0]              header_text;
  logic [LINE_CAP-1:0][7:0] line_buf;
  logic [FILL_W-1:0]        fill;
  logic [7:0]               datasum;
  logic [15:0]              line_addr;
  logic [15:0]              line_cnt;
  logic                     header_sent;
  logic                     need_line;
  logic                     is_end;
  logic                     accept;
  logic                     line_due;
  logic [7:0]               lin_count;
  logic [7:0]               hdr_sum;

  assign s_tready = (fstate == F_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign line_due = s_tuser ? (fill != '0) : (fill == FILL_W'(BYTES_PER_LINE - 1));
  assign lin_count = COUNT_BASE + 8'(fill);
  assign hdr_sum = COUNT_HDR + header_text[31:24] + header_text[23:16]
                 + header_text[15:8] + header_text[7:0];

  always_comb begin
    fstate_next = fstate;
    case (fstate)
      F_IDLE: begin
        if (s_tvalid) begin
          if (!header_sent) begin
            fstate_next = F_HDR;
          end else if (line_due) begin
            fstate_next = F_LINE;
          end else if (s_tuser) begin
            fstate_next = F_S5;
          end
        end
      end
      F_HDR: begin
        if (!fifo_st.full) begin
          if (need_line) begin
            fstate_next = F_LINE;
          end else if (is_end) begin
            fstate_next = F_S5;
          end else begin
            fstate_next = F_IDLE;
          end
        end
      end
      F_LINE: begin
        if (!fifo_st.full) begin
          fstate_next = is_end ? F_S5 : F_IDLE;
        end
      end
      F_S5: begin
        if (!fifo_st.full) begin
          fstate_next = F_S9;
        end
      end
      F_S9: begin
        if (!fifo_st.full) begin
          fstate_next = F_IDLE;
        end
      end
      default: fstate_next = F_IDLE;
    endcase
  end

  always_comb begin
    push     = 1'b0;
    push_rec = '0;
    case (fstate)
      F_HDR: begin
        push              = !fifo_st.full;
        push_rec.rtype    = REC_S0;
        push_rec.count    = COUNT_HDR;
        push_rec.data[0]  = header_text[31:24];
        push_rec.data[1]  = header_text[23:16];
        push_rec.data[2]  = header_text[15:8];
        push_rec.data[3]  = header_text[7:0];
        push_rec.cksum    = ~hdr_sum;
        push_rec.last     = !need_line && !is_end;
      end
      F_LINE: begin
        push           = !fifo_st.full;
        push_rec.rtype = REC_S1;
        push_rec.count = lin_count;
        push_rec.addr  = line_addr;
        push_rec.data  = line_buf;
        push_rec.cksum = ~(lin_count + line_addr[15:8] + line_addr[7:0] + datasum);
        push_rec.last  = !is_end;
      end
      F_S5: begin
        push           = !fifo_st.full;
        push_rec.rtype = REC_S5;
        push_rec.count = COUNT_BASE;
        push_rec.addr  = line_cnt;
        push_rec.cksum = ~(COUNT_BASE + line_cnt[15:8] + line_cnt[7:0]);
      end
      F_S9: begin
        push           = !fifo_st.full;
        push_rec.rtype = REC_S9;
        push_rec.count = COUNT_BASE;
        push_rec.cksum = ~COUNT_BASE;
        push_rec.last  = 1'b1;
      end
      default: push = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (accept && !s_tuser) begin
      line_buf[LINE_AW'(fill)] <= s_tdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fstate      <= F_IDLE;
      header_text <= '0;
      fill        <= '0;
      datasum     <= '0;
      line_addr   <= '0;
      line_cnt    <= '0;
      header_sent <= 1'b0;
      need_line   <= 1'b0;
      is_end      <= 1'b0;
    end else begin
      fstate <= fstate_next;
      if (cfg_we) begin
        header_text <= cfg_data;
      end
      if (accept) begin
        is_end    <= s_tuser;
        need_line <= line_due;
        if (!s_tuser) begin
          fill    <= fill + 1'b1;
          datasum <= datasum + s_tdata;
        end
      end
      if (push) begin
        case (fstate)
          F_HDR: header_sent <= 1'b1;
          F_LINE: begin
            fill      <= '0;
            datasum   <= '0;
            line_addr <= line_addr + 16'(BYTES_PER_LINE);
            line_cnt  <= line_cnt + 16'd1;
          end
          F_S9: begin
            header_sent <= 1'b0;
            fill        <= '0;
            datasum     <= '0;
            line_addr   <= '0;
            line_cnt    <= '0;
          end
          default: header_sent <= header_sent;
        endcase
      end
    end
  end

endmodule
`default_nettype wire

### rtl/srec_fifo.sv
// Short record queue between the front and back ends.
// Depends on srec_pkg.
`default_nettype none
module srec_fifo #(
  parameter int unsigned DEPTH = srec_pkg::FIFO_DEPTH
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  srec_pkg::record_t      push_rec,
  input  logic                   pop,
  output srec_pkg::record_t      pop_rec,
  output srec_pkg::fifo_status_t status
);
  import srec_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  record_t           entries [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [CNT_W-1:0]  count;

  assign status.full  = (count == CNT_W'(DEPTH));
  assign status.empty = (count == '0);
  assign pop_rec      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/srec_back.sv
// Back end: turns record descriptors into ASCII characters, one per cycle while m_tready does not stall the output.
// Depends on srec_pkg.
`default_nettype none
module srec_back (
  input  logic                   clk,
  input  logic                   rst,
  input  srec_pkg::record_t      pop_rec,
  input  srec_pkg::fifo_status_t fifo_st,
  output logic                   pop,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [7:0]             m_tdata,
  output logic                   m_tlast
);
  import srec_pkg::*;

  back_state_t         bstate, bstate_next;
  record_t             cur;
  logic [IDX_W-1:0]    idx;
  logic                nib;
  logic                can_load;
  logic                load;
  logic [6:0]          ch;
  logic [7:0]          sel_byte;
  logic [LINE_AW-1:0]  data_idx;
  logic                at_cksum;

  assign can_load = !m_tvalid || m_tready;
  assign data_idx = LINE_AW'(idx - IDX_W'(3));
  assign at_cksum = (8'(idx) == cur.count);

  always_comb begin
    if (idx == IDX_W'(0)) begin
      sel_byte = cur.count;
    end else if (idx == IDX_W'(1)) begin
      sel_byte = cur.addr[15:8];
    end else if (idx == IDX_W'(2)) begin
      sel_byte = cur.addr[7:0];
    end else if (at_cksum) begin
      sel_byte = cur.cksum;
    end else begin
      sel_byte = cur.data[data_idx];
    end
  end

  always_comb begin
    bstate_next = bstate;
    case (bstate)
      B_IDLE: begin
        if (!fifo_st.empty) begin
          bstate_next = B_S;
        end
      end
      B_S: begin
        if (can_load) begin
          bstate_next = B_TYPE;
        end
      end
      B_TYPE: begin
        if (can_load) begin
          bstate_next = B_HEX;
        end
      end
      B_HEX: begin
        if (can_load && nib && at_cksum) begin
          bstate_next = B_NL;
        end
      end
      B_NL: begin
        if (can_load) begin
          bstate_next = fifo_st.empty ? B_IDLE : B_S;
        end
      end
      default: bstate_next = B_IDLE;
    endcase
  end

  always_comb begin
    pop  = 1'b0;
    load = 1'b0;
    ch   = CHAR_S;
    case (bstate)
      B_IDLE: pop = !fifo_st.empty;
      B_S: begin
        load = can_load;
        ch   = CHAR_S;
      end
      B_TYPE: begin
        load = can_load;
        ch   = hex_char(cur.rtype);
      end
      B_HEX: begin
        load = can_load;
        ch   = nib ? hex_char(sel_byte[3:0]) : hex_char(sel_byte[7:4]);
      end
      B_NL: begin
        load = can_load;
        ch   = CHAR_NL;
        pop  = can_load && !fifo_st.empty;
      end
      default: pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= pop_rec;
    end
    if (load) begin
      m_tdata <= {1'b0, ch};
      m_tlast <= (bstate == B_NL) && cur.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bstate   <= B_IDLE;
      m_tvalid <= 1'b0;
      idx      <= '0;
      nib      <= 1'b0;
    end else begin
      bstate <= bstate_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (pop) begin
        idx <= '0;
        nib <= 1'b0;
      end else if (load && (bstate == B_HEX)) begin
        if (nib) begin
          nib <= 1'b0;
          idx <= idx + 1'b1;
        end else begin
          nib <= 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

### rtl/srec_record_encoder_core.sv
// S-record (S0/S1/S5/S9) text encoder: byte stream in, ASCII characters out.
// Input channel s_*: tdata = data_byte, tuser = func (1 = end of stream).
// Output channel m_*: tdata = out_char (bit 7 zero), tlast marks the last
// character caused by an input item. cfg_we/cfg_data write the four S0
// header bytes, most significant first.
// A quiet data byte is taken without dropping s_tready. An item that causes
// records holds s_tready low while building them (up to four); records wait
// in a two-entry queue. The character sequencer emits one character per
// cycle when m_tready allows: 2 + 2 * (count + 1) + 1 characters per record,
// 43 for a full S1 line, passing through its idle state when the queue runs
// empty between records, and sets the sustained rate. The first character
// goes through the front state register, the queue and the output register.
// A stalled m_tready holds the output register; the queue then fills and
// s_tready drops. Reset returns the file state to its start and clears the
// header register; the next item opens a new file with an S0 record.
`default_nettype none
`include "srec_record_encoder_core_macros.svh"
module srec_record_encoder_core #(
  parameter int unsigned BYTES_PER_LINE = srec_pkg::BPL_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [31:0] cfg_data,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] data_byte
  input  logic        s_tuser,   // [0] func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [6:0] out_char, [7] zero
  output logic        m_tlast
);
  import srec_pkg::*;

  logic         push;
  logic         pop;
  record_t      push_rec;
  record_t      pop_rec;
  fifo_status_t fifo_st;

  srec_front #(
    .BYTES_PER_LINE(BYTES_PER_LINE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .push     (push),
    .push_rec (push_rec),
    .fifo_st  (fifo_st)
  );

  srec_fifo #(
    .DEPTH(FIFO_DEPTH)
  ) u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_rec (push_rec),
    .pop      (pop),
    .pop_rec  (pop_rec),
    .status   (fifo_st)
  );

  srec_back u_back (
    .clk      (clk),
    .rst      (rst),
    .pop_rec  (pop_rec),
    .fifo_st  (fifo_st),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  `SREC_ASSERT(a_tlast_newline, m_tvalid && m_tlast |-> m_tdata[6:0] == CHAR_NL, "tlast off newline")
  `SREC_ASSERT(a_no_overflow, push |-> !fifo_st.full, "push into full queue")
  `SREC_ASSERT(a_no_underflow, pop |-> !fifo_st.empty, "pop from empty queue")
  `SREC_ASSERT_NEXT(a_end_busy, s_tvalid && s_tready && s_tuser, !s_tready, "end item not held")

endmodule
`default_nettype wire

### tb/srec_record_encoder_core_tb.sv
// Self-checking testbench for srec_record_encoder_core: streams bytes and end items in,
// predicts the S-record text per accepted transfer and checks every output character.
// Depends on srec_pkg and the RTL of srec_record_encoder_core.
`default_nettype none
module srec_record_encoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import srec_pkg::*;

  localparam bit FUNC_DATA = 1'b0;
  localparam bit FUNC_END = 1'b1;
  localparam int unsigned LINE_BYTES = BPL_DEFAULT;
  localparam int unsigned RANDOM_ITEMS = 350;
  localparam int unsigned SETTLE_CYCLES = 16;

  typedef struct packed {
    logic [6:0] ch;
    logic last;
  } srec_char_t;

  class srec_text_model;
    logic [7:0] line_buf [16];
    int unsigned fill;
    logic [15:0] line_num;
    bit hdr_sent;
    logic [31:0] header;
    srec_char_t pending [$];
    int unsigned mismatches;

    function new();
      header = '0;
      mismatches = 0;
      clear_file();
    endfunction

    function void clear_file();
      foreach (line_buf[i]) line_buf[i] = '0;
      fill = 0;
      line_num = '0;
      hdr_sent = 1'b0;
    endfunction

    function logic [6:0] hex_of(logic [3:0] v);
      string digits = "0123456789ABCDEF";
      byte c;
      c = digits[v];
      return c[6:0];
    endfunction

    function void put_char(logic [6:0] c);
      srec_char_t e;
      e.ch = c;
      e.last = 1'b0;
      pending.push_back(e);
    endfunction

    function void put_hex(logic [7:0] v);
      put_char(hex_of(v[7:4]));
      put_char(hex_of(v[3:0]));
    endfunction

    function void put_record(logic [3:0] rtype, logic [15:0] addr, logic [7:0] bytes [16],
                             int unsigned n);
      logic [7:0] count;
      logic [7:0] sum;
      count = COUNT_BASE + 8'(n);
      sum = count + addr[15:8] + addr[7:0];
      put_char(CHAR_S);
      put_char(hex_of(rtype));
      put_hex(count);
      put_hex(addr[15:8]);
      put_hex(addr[7:0]);
      for (int unsigned i = 0; i < n; i++) begin
        put_hex(bytes[i]);
        sum = sum + bytes[i];
      end
      put_hex(~sum);
      put_char(CHAR_NL);
    endfunction

    function void flush_line();
      put_record(REC_S1, 16'(line_num * LINE_BYTES), line_buf, fill);
      line_num = line_num + 16'd1;
      fill = 0;
    endfunction

    function void note_input(bit func, logic [7:0] data_byte);
      int unsigned start;
      logic [7:0] hdr [16];
      srec_char_t tail_c;
      start = pending.size();
      if (!hdr_sent) begin
        foreach (hdr[i]) hdr[i] = '0;
        hdr[0] = header[31:24];
        hdr[1] = header[23:16];
        hdr[2] = header[15:8];
        hdr[3] = header[7:0];
        put_record(REC_S0, 16'h0000, hdr, 4);
        hdr_sent = 1'b1;
      end
      if (func == FUNC_DATA) begin
        line_buf[fill] = data_byte;
        fill++;
        if (fill >= LINE_BYTES) flush_line();
      end else begin
        if (fill > 0) flush_line();
        put_record(REC_S5, line_num, line_buf, 0);
        put_record(REC_S9, 16'h0000, line_buf, 0);
        clear_file();
      end
      if (pending.size() > start) begin
        tail_c = pending.pop_back();
        tail_c.last = 1'b1;
        pending.push_back(tail_c);
      end
    endfunction

    task report(string what, logic [7:0] got, logic [7:0] want);
      mismatches++;
      if (mismatches <= 40)
        $display("[%0t] mismatch on %s: got %h, expected %h", $realtime, what, got, want);
    endtask

    task check_char(logic [7:0] data, logic last);
      srec_char_t want;
      if (pending.size() == 0) begin
        report("transfer with no character pending", data, 8'h00);
        return;
      end
      want = pending.pop_front();
      if (data !== {1'b0, want.ch}) report("character", data, {1'b0, want.ch});
      if (last !== want.last) report("tlast", {7'd0, last}, {7'd0, want.last});
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [31:0] cfg_data = '0;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tlast;

  srec_text_model enc = new();
  bit src_steady = 1'b0;
  bit sink_steady = 1'b0;
  int unsigned sink_hold = 0;
  int unsigned items_sent = 0;

  srec_record_encoder_core DUT (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 24);
  endfunction

  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_file_len();
    case ($urandom_range(0, 9))
      0: return 0;
      1: return 15;
      2: return 16;
      3: return $urandom_range(31, 32);
      4: return $urandom_range(33, 60);
      default: return $urandom_range(1, 14);
    endcase
  endfunction

  always @(posedge clk) begin
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      m_tready <= 1'b0;
    end else if (!sink_steady && $urandom_range(0, 5) == 0) begin
      sink_hold <= pick_gap();
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) enc.check_char(m_tdata, m_tlast);
  end

  task send_item(bit func, logic [7:0] data_byte);
    int unsigned gap;
    gap = src_steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= func;
    s_tdata <= data_byte;
    do @(posedge clk); while (!s_tready);
    enc.note_input(func, data_byte);
    items_sent++;
  endtask

  task send_file(int unsigned len);
    for (int unsigned i = 0; i < len; i++) send_item(FUNC_DATA, pick_byte());
    send_item(FUNC_END, 8'($urandom_range(0, 255)));
  endtask

  // hold the input until every pending character has gone out
  task quiesce();
    s_tvalid <= 1'b0;
    while (enc.pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task write_header(logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    enc.header = value;
  endtask

  initial begin
    logic [7:0] line_pattern [16];
    line_pattern = '{8'h00, 8'hFF, 8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20,
                     8'h40, 8'h80, 8'hAA, 8'h55, 8'hFE, 8'h7F, 8'h0F, 8'hF0};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_item(FUNC_END, 8'hFF);
    quiesce();
    write_header(32'hFFFF_FFFF);
    foreach (line_pattern[i]) send_item(FUNC_DATA, line_pattern[i]);
    send_item(FUNC_DATA, 8'h12);
    send_item(FUNC_DATA, 8'h34);
    send_item(FUNC_DATA, 8'h56);
    send_item(FUNC_END, 8'h00);
    quiesce();
    write_header(32'h0000_0000);

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      if ($urandom_range(0, 5) == 0) begin
        quiesce();
        case ($urandom_range(0, 3))
          0: write_header(32'h0000_0000);
          1: write_header(32'hFFFF_FFFF);
          default: write_header($urandom);
        endcase
      end
      src_steady = ($urandom_range(0, 3) == 0);
      sink_steady <= ($urandom_range(0, 3) == 0);
      send_file(pick_file_len());
    end

    sink_steady <= 1'b0;
    quiesce();
    repeat (40) @(posedge clk);
    if (enc.mismatches == 0 && enc.pending.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire

### filelist.f
+incdir+rtl
rtl/srec_pkg.sv
rtl/srec_front.sv
rtl/srec_fifo.sv
rtl/srec_back.sv
rtl/srec_record_encoder_core.sv
tb/srec_record_encoder_core_tb.sv
